// ===== rtl/cmav_pkg.sv =====
// Shared definitions for the centered moving average block.
// Holds default sizes, the register width and the queue command codes.
// No dependencies.
`timescale 1ns / 1ps

package cmav_pkg;

  localparam int DEF_MAX_HALF     = 8;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam int WHALF_W = 4;
  localparam logic [WHALF_W-1:0] WHALF_RESET = 4'd1;

  typedef enum logic {
    CMD_SHIFT = 1'b0,
    CMD_MEAN  = 1'b1
  } cmd_op_t;

endpackage

// ===== rtl/cmav_fifo.sv =====
// Small command queue between the front and back sections.
// Register-based FIFO, fall-through read of the head entry.
// No package dependencies.
`timescale 1ns / 1ps

module cmav_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_r [0:DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W:0]    count_r;

  assign full     = (count_r == (PTR_W+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/cmav_front.sv =====
// Front section: accepts input words, holds the window_half register and
// the stream position counters, and issues shift and mean commands.
// Depends on cmav_pkg.
`timescale 1ns / 1ps

module cmav_front #(
  parameter int MAX_HALF     = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cmav_pkg::WHALF_W-1:0]            cfg_window_half,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]          in_sample,
  input  logic                                    in_last,
  output logic                                    q_push,
  output logic [1+1+$clog2(2*MAX_HALF+1)+$clog2(2*MAX_HALF+2)+SAMPLE_WIDTH-1:0]
                                                  q_data,
  input  logic                                    q_full
);
  import cmav_pkg::*;

  localparam int IDX_W    = $clog2(2*MAX_HALF+1);
  localparam int CNT_W    = $clog2(2*MAX_HALF+2);
  localparam int SEEN_W   = $clog2(3*MAX_HALF+2);
  localparam int W_W      = $clog2(MAX_HALF+1);
  localparam int SEEN_CAP = 3*MAX_HALF+1;
  localparam int WIN_CAP  = 2*MAX_HALF+1;

  logic [WHALF_W-1:0] window_half_r;
  logic [SEEN_W-1:0]  seen_r;
  logic [CNT_W-1:0]   nop_r;
  logic [CNT_W-1:0]   stop_r;
  logic [W_W-1:0]     w_r;
  logic               last_item_r;
  logic               busy_r;

  logic               in_acc;
  logic [W_W-1:0]     w_eff;
  logic [SEEN_W-1:0]  seen_inc;
  logic [CNT_W-1:0]   nop_inc;
  logic [CNT_W-1:0]   stop_nxt;
  logic [CNT_W-1:0]   d;
  logic [CNT_W-1:0]   w_ext;
  logic [CNT_W-1:0]   right;
  logic [SEEN_W-1:0]  older;
  logic [SEEN_W-1:0]  w_seen;
  logic [CNT_W-1:0]   left;
  logic [IDX_W-1:0]   start;
  logic [CNT_W-1:0]   cnt;
  logic               mean_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r | q_full;
  assign in_acc    = in_valid & ~in_stall;
  assign q_push    = in_acc | (busy_r & ~q_full);

  always_comb begin
    if (32'(window_half_r) > MAX_HALF) begin
      w_eff = W_W'(MAX_HALF);
    end else begin
      w_eff = W_W'(window_half_r);
    end
    seen_inc = (32'(seen_r) < SEEN_CAP) ? seen_r + 1'b1 : seen_r;
    nop_inc  = (32'(nop_r) < WIN_CAP) ? nop_r + 1'b1 : nop_r;
    stop_nxt = in_last ? '0 : CNT_W'(w_eff);

    d     = nop_r - 1'b1;
    w_ext = CNT_W'(w_r);
    right = (d < w_ext) ? d : w_ext;
    if ((SEEN_W+1)'(seen_r) >= (SEEN_W+1)'(nop_r)) begin
      older = seen_r - SEEN_W'(nop_r);
    end else begin
      older = '0;
    end
    w_seen    = SEEN_W'(w_r);
    left      = (older < w_seen) ? CNT_W'(older) : w_ext;
    start     = IDX_W'(d - right);
    cnt       = left + right + 1'b1;
    mean_last = last_item_r & (d == stop_r);

    if (busy_r) begin
      q_data = {CMD_MEAN, mean_last, start, cnt, {SAMPLE_WIDTH{1'b0}}};
    end else begin
      q_data = {CMD_SHIFT, 1'b0, {IDX_W{1'b0}}, {CNT_W{1'b0}}, in_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_half_r <= WHALF_RESET;
      seen_r        <= '0;
      nop_r         <= '0;
      stop_r        <= '0;
      w_r           <= '0;
      last_item_r   <= 1'b0;
      busy_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_half_r <= cfg_window_half;
      end
      if (in_acc) begin
        seen_r      <= seen_inc;
        nop_r       <= nop_inc;
        stop_r      <= stop_nxt;
        w_r         <= w_eff;
        last_item_r <= in_last;
        busy_r      <= (nop_inc > stop_nxt);
      end else if (busy_r && !q_full) begin
        nop_r <= d;
        if (d == stop_r) begin
          busy_r <= 1'b0;
          if (last_item_r) begin
            seen_r <= '0;
            nop_r  <= '0;
          end
        end
      end
    end
  end

  a_busy_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> nop_r != '0)
    else $error("front busy with no pending position");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !q_full && mean_last) |=> (!busy_r && nop_r == '0 && seen_r == '0))
    else $error("stream end did not clear counters");

  a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(seen_r) <= SEEN_CAP)
    else $error("sample count above cap");

endmodule

// ===== rtl/cmav_back.sv =====
// Back section: executes queued commands, keeps the sample window,
// sums a window one tap per cycle and divides by reciprocal multiply.
// Depends on cmav_pkg.
`timescale 1ns / 1ps

module cmav_back #(
  parameter int MAX_HALF     = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  output logic                                    q_pop,
  input  logic [1+1+$clog2(2*MAX_HALF+1)+$clog2(2*MAX_HALF+2)+SAMPLE_WIDTH-1:0]
                                                  q_data,
  input  logic                                    q_empty,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]          out_average,
  output logic                                    out_last_res
);
  import cmav_pkg::*;

  localparam int WIN_DEPTH = 2*MAX_HALF+1;
  localparam int IDX_W     = $clog2(2*MAX_HALF+1);
  localparam int CNT_W     = $clog2(2*MAX_HALF+2);
  localparam int SUM_W     = SAMPLE_WIDTH + $clog2(2*MAX_HALF+1);
  localparam int RCP_S     = SUM_W + 1;
  localparam int TAB_N     = 1 << CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_NRM,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } state_t;

  state_t                       state_r;
  logic signed [SAMPLE_WIDTH-1:0] win_r [0:WIN_DEPTH-1];
  logic [IDX_W-1:0]             k_r;
  logic [CNT_W-1:0]             rem_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         last_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic [RCP_S-1:0]             n_r;
  logic                         neg_r;
  logic [2*RCP_S-1:0]           prod_r;
  logic                         out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_avg_r;
  logic                         out_last_r;

  logic [RCP_S-1:0]             rcp_tab [0:TAB_N-1];

  logic                         cmd_op;
  logic                         cmd_last;
  logic [IDX_W-1:0]             cmd_start;
  logic [CNT_W-1:0]             cmd_cnt;
  logic signed [SAMPLE_WIDTH-1:0] cmd_sample;

  logic [SUM_W-1:0]             mag;
  logic [CNT_W:0]               dv;
  logic [RCP_S-1:0]             q0;
  logic [RCP_S-1:0]             qd;
  logic [RCP_S-1:0]             rem_q;
  logic [RCP_S-1:0]             q;
  logic [RCP_S-1:0]             q_signed;

  for (genvar g = 0; g < TAB_N; g++) begin : g_rcp
    if (g == 0) begin : g_zero
      assign rcp_tab[g] = '0;
    end else begin : g_val
      localparam logic [63:0] RV = (64'd1 << RCP_S) / (64'(2*g));
      assign rcp_tab[g] = RV[RCP_S-1:0];
    end
  end

  assign {cmd_op, cmd_last, cmd_start, cmd_cnt, cmd_sample} = q_data;
  assign q_pop        = (state_r == ST_IDLE) & ~q_empty;
  assign out_valid    = out_valid_r;
  assign out_average  = out_avg_r;
  assign out_last_res = out_last_r;

  always_comb begin
    mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    dv       = {cnt_r, 1'b0};
    q0       = prod_r[2*RCP_S-1:RCP_S];
    qd       = RCP_S'(q0 * RCP_S'(dv));
    rem_q    = n_r - qd;
    q        = (rem_q >= RCP_S'(dv)) ? q0 + 1'b1 : q0;
    q_signed = neg_r ? RCP_S'(-q) : q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (cmd_op == CMD_SHIFT) begin
              for (int i = WIN_DEPTH-1; i > 0; i--) begin
                win_r[i] <= win_r[i-1];
              end
              win_r[0] <= cmd_sample;
            end else begin
              k_r     <= cmd_start;
              rem_r   <= cmd_cnt;
              cnt_r   <= cmd_cnt;
              last_r  <= cmd_last;
              sum_r   <= '0;
              state_r <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          sum_r <= sum_r + SUM_W'(win_r[k_r]);
          k_r   <= k_r + 1'b1;
          rem_r <= rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_r <= ST_NRM;
          end
        end
        ST_NRM: begin
          neg_r   <= sum_r[SUM_W-1];
          n_r     <= {mag, 1'b0} + RCP_S'(cnt_r);
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= (2*RCP_S)'(n_r) * (2*RCP_S)'(rcp_tab[cnt_r]);
          state_r <= ST_FIX;
        end
        ST_FIX: begin
          out_avg_r   <= q_signed[SAMPLE_WIDTH-1:0];
          out_last_r  <= last_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_valid_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == ST_OUT))
    else $error("result valid outside output state");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !out_valid_r))
    else $error("command taken while busy");

  a_acc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (rem_r != '0 && cnt_r != '0))
    else $error("accumulating an empty window");

endmodule

// ===== rtl/centered_moving_average_top.sv =====
// Top level of the centered moving average block.
// Instantiates cmav_front, cmav_fifo and cmav_back; depends on cmav_pkg.
// Usage:
//   Input channel (in_valid / in_stall): one word per sample, in_sample is
//   signed Q8.8, in_last marks the final sample of a stream and flushes it.
//   Result channel (out_valid / out_stall): out_average is the rounded mean
//   of the in-range samples within window_half positions of one position,
//   out_last_res marks the final result of a stream.
//   Config channel (cfg_valid / cfg_ready): writes window_half; ready is
//   always high. Write it only while no stream work is outstanding.
//   Throughput: the front takes no new sample while it issues the mean
//   commands that a sample releases, or while the command queue is full.
//   Each result passes ST_IDLE, ST_ACC, ST_NRM, ST_MUL, ST_FIX and ST_OUT
//   in the back section, which takes no new command until the result has
//   left ST_OUT. ST_ACC sums the window taps one tap per cycle; their
//   count is at most 2*MAX_HALF+1.
//   Reset: synchronous, active low; window_half returns to 1, all counters
//   and the queue clear, no result is pending.
//   Stall: a result holds on the outputs while out_stall is high; the queue
//   keeps taking samples until it fills, then in_stall rises.
`timescale 1ns / 1ps

module centered_moving_average_top #(
  parameter int MAX_HALF     = cmav_pkg::DEF_MAX_HALF,
  parameter int SAMPLE_WIDTH = cmav_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cmav_pkg::WHALF_W-1:0]   cfg_window_half,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_average,
  output logic                           out_last_res
);
  import cmav_pkg::*;

  localparam int IDX_W  = $clog2(2*MAX_HALF+1);
  localparam int CNT_W  = $clog2(2*MAX_HALF+2);
  localparam int DATA_W = 2 + IDX_W + CNT_W + SAMPLE_WIDTH;

  logic              q_push;
  logic [DATA_W-1:0] q_push_data;
  logic              q_full;
  logic              q_pop;
  logic [DATA_W-1:0] q_pop_data;
  logic              q_empty;

  cmav_front #(
    .MAX_HALF     (MAX_HALF),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_window_half (cfg_window_half),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .q_push          (q_push),
    .q_data          (q_push_data),
    .q_full          (q_full)
  );

  cmav_fifo #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  cmav_back #(
    .MAX_HALF     (MAX_HALF),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_pop        (q_pop),
    .q_data       (q_pop_data),
    .q_empty      (q_empty),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_average  (out_average),
    .out_last_res (out_last_res)
  );

endmodule
